// ===== rtl/lmid_pkg.sv =====
// lmid_pkg: shared widths, payload types and register codes for the
// periodic lieb lattice minimum image distance block
// no dependencies
package lmid_pkg;

  localparam int SITE_W     = 14;
  localparam int DIST_W     = 17;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_SIDE_DEF = 64;

  // site / 3 as a reciprocal multiply, exact for every 14-bit index
  localparam int CELL_W      = 13;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP = 15'd21846;

  localparam logic [CFG_W-1:0]  SIDE_RESET = 7'd4;
  localparam logic [DIST_W-1:0] DIST_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATTICE_WIDTH  = 1'b0,
    CFG_LATTICE_LENGTH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SITE_W-1:0] site_a;
    logic [SITE_W-1:0] site_b;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] squared_distance;
    logic              site_out_of_range;
  } out_item_t;

endpackage

// ===== rtl/lmid_stream_if.sv =====
// lmid_stream_if: valid/ready stream channel with a typed payload
// payload type comes from lmid_pkg at the instance
interface lmid_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lieb_min_image_distance.sv =====
// lieb_min_image_distance: pipelined minimum image squared distance
// throughput: one site pair per cycle unless the pipeline is full and the output
// stalls; depth set by the one-bit-per-stage restoring divider that splits each
// cell index into x and y
// reset: lattice width and length return to 4, all pipeline stages emptied
// uses lmid_pkg and lmid_stream_if
module lieb_min_image_distance #(
  parameter int MAX_SIDE = lmid_pkg::MAX_SIDE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lmid_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lmid_pkg::CFG_W-1:0]     cfg_data_i,
  lmid_stream_if.sink                    in_i,
  lmid_stream_if.source                  out_o
);

  localparam int SITE_W  = lmid_pkg::SITE_W;
  localparam int CELL_W  = lmid_pkg::CELL_W;
  localparam int DIST_W  = lmid_pkg::DIST_W;
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int QW      = $clog2(MAX_SIDE);
  localparam int PROD_W  = SITE_W + lmid_pkg::RECIP_W;
  localparam int CMP_W   = (CELL_W > SIDE_W + QW) ? CELL_W : SIDE_W + QW;
  localparam int SITES_W = 2 * SIDE_W + 2;
  localparam int CMPS_W  = (SITES_W > SITE_W) ? SITES_W : SITE_W;
  localparam int PX_W    = QW + 1;
  localparam int D_W     = QW + 3;
  localparam int MAG_W   = QW + 2;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int SAT_W   = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  // stage numbering
  localparam int ST_DEC  = QW + 2;
  localparam int ST_DIFF = QW + 3;
  localparam int ST_SQ   = QW + 4;
  localparam int ST_MIN  = QW + 5;
  localparam int ST_OUT  = QW + 6;
  localparam int NS      = QW + 7;

  typedef struct packed {
    logic [CELL_W-1:0] rem;
    logic [QW-1:0]     quo;
    logic [1:0]        k;
  } div_site_t;

  typedef struct packed {
    div_site_t a;
    div_site_t b;
    logic      oor;
  } div_t;

  typedef struct packed {
    logic [PX_W-1:0] pxa;
    logic [PX_W-1:0] pya;
    logic [PX_W-1:0] pxb;
    logic [PX_W-1:0] pyb;
    logic            qxa;
    logic            qya;
    logic            qxb;
    logic            qyb;
    logic            oor;
  } dec_t;

  typedef struct packed {
    logic signed [D_W-1:0] dx0;
    logic signed [D_W-1:0] dx1;
    logic signed [D_W-1:0] dy0;
    logic signed [D_W-1:0] dy1;
    logic                  oor;
  } diff_t;

  typedef struct packed {
    logic [SQ_W-1:0] x0;
    logic [SQ_W-1:0] x1;
    logic [SQ_W-1:0] y0;
    logic [SQ_W-1:0] y1;
    logic            oor;
  } sq_t;

  typedef struct packed {
    logic [SQ_W-1:0] xm;
    logic [SQ_W-1:0] ym;
    logic            oor;
  } min_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [D_W-1:0] v);
    logic signed [D_W-1:0] n;
    n = -v;
    return v[D_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

  // configuration
  logic [lmid_pkg::CFG_W-1:0] cfg_w_q, cfg_l_q;
  logic [SIDE_W-1:0]          w_c, l_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= lmid_pkg::SIDE_RESET;
      cfg_l_q <= lmid_pkg::SIDE_RESET;
    end else if (cfg_we_i) begin
      case (lmid_pkg::cfg_reg_e'(cfg_idx_i))
        lmid_pkg::CFG_LATTICE_WIDTH:  cfg_w_q <= cfg_data_i;
        lmid_pkg::CFG_LATTICE_LENGTH: cfg_l_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_q == '0) begin
      w_c = SIDE_W'(1);
    end else if (int'(cfg_w_q) > MAX_SIDE) begin
      w_c = SIDE_W'(MAX_SIDE);
    end else begin
      w_c = SIDE_W'(cfg_w_q);
    end
    if (cfg_l_q == '0) begin
      l_c = SIDE_W'(1);
    end else if (int'(cfg_l_q) > MAX_SIDE) begin
      l_c = SIDE_W'(MAX_SIDE);
    end else begin
      l_c = SIDE_W'(cfg_l_q);
    end
  end

  // flow control: a stage moves on output ready or when it or a later stage is empty
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = out_o.ready || !(&v_q[NS-1:i]);
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // stage 0: input register
  lmid_pkg::in_item_t in_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      in_q <= in_i.payload;
    end
  end

  // stage 1: cell and site-in-cell, range check
  logic [PROD_W-1:0]     prod_a, prod_b;
  logic [CELL_W-1:0]     cell_a, cell_b;
  logic [SITE_W-1:0]     three_a, three_b;
  logic [2*SIDE_W-1:0]   wl;
  logic [SITES_W-1:0]    sites;
  div_t                  div_d;
  div_t                  div_q [QW+1];

  always_comb begin
    prod_a  = PROD_W'(in_q.site_a) * PROD_W'(lmid_pkg::RECIP);
    prod_b  = PROD_W'(in_q.site_b) * PROD_W'(lmid_pkg::RECIP);
    cell_a  = prod_a[lmid_pkg::RECIP_SHIFT +: CELL_W];
    cell_b  = prod_b[lmid_pkg::RECIP_SHIFT +: CELL_W];
    three_a = SITE_W'({cell_a, 1'b0}) + SITE_W'(cell_a);
    three_b = SITE_W'({cell_b, 1'b0}) + SITE_W'(cell_b);
    wl      = (2*SIDE_W)'(w_c) * (2*SIDE_W)'(l_c);
    sites   = SITES_W'({wl, 1'b0}) + SITES_W'(wl);
    div_d.a.rem = cell_a;
    div_d.a.quo = '0;
    div_d.a.k   = 2'(in_q.site_a - three_a);
    div_d.b.rem = cell_b;
    div_d.b.quo = '0;
    div_d.b.k   = 2'(in_q.site_b - three_b);
    div_d.oor   = (CMPS_W'(in_q.site_a) >= CMPS_W'(sites)) ||
                  (CMPS_W'(in_q.site_b) >= CMPS_W'(sites));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      div_q[0] <= div_d;
    end
  end

  // restoring divider, one quotient bit per stage: y = cell / w, x = remainder
  for (genvar d = 0; d < QW; d++) begin : g_div
    localparam int B = QW - 1 - d;
    logic [CMP_W-1:0] dv, ra, rb;
    div_t             nx;

    always_comb begin
      dv = CMP_W'(w_c) << B;
      ra = CMP_W'(div_q[d].a.rem);
      rb = CMP_W'(div_q[d].b.rem);
      nx = div_q[d];
      if (ra >= dv) begin
        nx.a.rem = CELL_W'(ra - dv);
        nx.a.quo = div_q[d].a.quo | (QW'(1) << B);
      end
      if (rb >= dv) begin
        nx.b.rem = CELL_W'(rb - dv);
        nx.b.quo = div_q[d].b.quo | (QW'(1) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[d+2]) begin
        div_q[d+1] <= nx;
      end
    end
  end

  // doubled coordinates and quarter flags
  logic [SIDE_W-1:0] half_w, half_l;
  dec_t              dec_d, dec_q;

  always_comb begin
    half_w    = SIDE_W'(({1'b0, w_c} + 1'b1) >> 1);
    half_l    = SIDE_W'(({1'b0, l_c} + 1'b1) >> 1);
    dec_d.pxa = {div_q[QW].a.rem[QW-1:0], div_q[QW].a.k[0]};
    dec_d.pya = {div_q[QW].a.quo, div_q[QW].a.k[1]};
    dec_d.pxb = {div_q[QW].b.rem[QW-1:0], div_q[QW].b.k[0]};
    dec_d.pyb = {div_q[QW].b.quo, div_q[QW].b.k[1]};
    dec_d.qxa = SIDE_W'(div_q[QW].a.rem[QW-1:0]) >= half_w;
    dec_d.qya = SIDE_W'(div_q[QW].a.quo) >= half_l;
    dec_d.qxb = SIDE_W'(div_q[QW].b.rem[QW-1:0]) >= half_w;
    dec_d.qyb = SIDE_W'(div_q[QW].b.quo) >= half_l;
    dec_d.oor = div_q[QW].oor;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DEC]) begin
      dec_q <= dec_d;
    end
  end

  // direct and shifted differences; shift goes to the site in the lower quarter
  logic signed [D_W-1:0] sx, sy, dx, dy;
  diff_t                 diff_d, diff_q;

  always_comb begin
    sx = $signed(D_W'({w_c, 1'b0}));
    sy = $signed(D_W'({l_c, 1'b0}));
    dx = $signed(D_W'(dec_q.pxa)) - $signed(D_W'(dec_q.pxb));
    dy = $signed(D_W'(dec_q.pya)) - $signed(D_W'(dec_q.pyb));
    diff_d.dx0 = dx;
    diff_d.dy0 = dy;
    diff_d.dx1 = dx;
    diff_d.dy1 = dy;
    if (dec_q.qxa != dec_q.qxb) begin
      diff_d.dx1 = dec_q.qxa ? dx - sx : dx + sx;
    end
    if (dec_q.qya != dec_q.qyb) begin
      diff_d.dy1 = dec_q.qya ? dy - sy : dy + sy;
    end
    diff_d.oor = dec_q.oor;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DIFF]) begin
      diff_q <= diff_d;
    end
  end

  // squares of each axis candidate
  sq_t sq_d, sq_q;

  always_comb begin
    sq_d.x0  = SQ_W'(mag(diff_q.dx0)) * SQ_W'(mag(diff_q.dx0));
    sq_d.x1  = SQ_W'(mag(diff_q.dx1)) * SQ_W'(mag(diff_q.dx1));
    sq_d.y0  = SQ_W'(mag(diff_q.dy0)) * SQ_W'(mag(diff_q.dy0));
    sq_d.y1  = SQ_W'(mag(diff_q.dy1)) * SQ_W'(mag(diff_q.dy1));
    sq_d.oor = diff_q.oor;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SQ]) begin
      sq_q <= sq_d;
    end
  end

  // the least image splits per axis, so each axis keeps its smaller candidate
  min_t min_d, min_q;

  always_comb begin
    min_d.xm  = (sq_q.x1 < sq_q.x0) ? sq_q.x1 : sq_q.x0;
    min_d.ym  = (sq_q.y1 < sq_q.y0) ? sq_q.y1 : sq_q.y0;
    min_d.oor = sq_q.oor;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_MIN]) begin
      min_q <= min_d;
    end
  end

  // sum, saturate, out-of-range override
  logic [SUM_W-1:0]    sum;
  lmid_pkg::out_item_t out_d, out_q;

  always_comb begin
    sum = SUM_W'(min_q.xm) + SUM_W'(min_q.ym);
    if (min_q.oor) begin
      out_d.squared_distance = '0;
    end else if (SAT_W'(sum) > SAT_W'(lmid_pkg::DIST_MAX)) begin
      out_d.squared_distance = lmid_pkg::DIST_MAX;
    end else begin
      out_d.squared_distance = DIST_W'(sum);
    end
    out_d.site_out_of_range = min_q.oor;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = v_q[NS-1];
  assign out_o.payload = out_q;

endmodule

// ===== tb/sv/lieb_min_image_distance_test.sv =====
// lieb_min_image_distance_test: stream testbench for the lieb lattice minimum image block
// drives site pairs and lattice sizes, predicts each distance and checks it in order
// depends on lmid_pkg, lmid_stream_if and lieb_min_image_distance
`timescale 1ns / 1ps

module lieb_min_image_distance_test;

  localparam int SITE_W        = lmid_pkg::SITE_W;
  localparam int DIST_W        = lmid_pkg::DIST_W;
  localparam int CFG_W         = lmid_pkg::CFG_W;
  localparam int CFG_IDX_W     = lmid_pkg::CFG_IDX_W;
  localparam int NUM_PHASES    = 10;
  localparam int PAIRS_PER_PH  = 125;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int SITE_TOP      = (1 << SITE_W) - 1;

  class lattice_distance_board;
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    length_reg;
    lmid_pkg::out_item_t expected_dist_q[$];
    int                  errors;

    function new();
      width_reg  = lmid_pkg::SIDE_RESET;
      length_reg = lmid_pkg::SIDE_RESET;
      errors     = 0;
    endfunction

    function void set_reg(lmid_pkg::cfg_reg_e idx, logic [CFG_W-1:0] v);
      case (idx)
        lmid_pkg::CFG_LATTICE_WIDTH:  width_reg = v;
        lmid_pkg::CFG_LATTICE_LENGTH: length_reg = v;
        default: ;
      endcase
    endfunction

    // zero counts as one cell, anything past the max side is clipped
    function int side_used(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > lmid_pkg::MAX_SIDE_DEF) return lmid_pkg::MAX_SIDE_DEF;
      return int'(v);
    endfunction

    function void place_site(int s, int w, int l, output int px, output int py,
                             output bit qx, output bit qy);
      int cell_idx, k, x, y;
      cell_idx = s / 3;
      k        = s % 3;
      x        = cell_idx % w;
      y        = cell_idx / w;
      px       = 2 * x + k % 2;
      py       = 2 * y + k / 2;
      qx       = (x >= (w + 1) / 2);
      qy       = (y >= (l + 1) / 2);
    endfunction

    function int sep2(int dx, int dy);
      return dx * dx + dy * dy;
    endfunction

    function lmid_pkg::out_item_t min_image(lmid_pkg::in_item_t pair);
      int w, l, sites, sx, sy, best, cand;
      int ax, ay, bx, by;
      bit aqx, aqy, bqx, bqy;
      lmid_pkg::out_item_t res;
      w     = side_used(width_reg);
      l     = side_used(length_reg);
      sites = 3 * w * l;
      res   = '0;
      if (int'(pair.site_a) >= sites || int'(pair.site_b) >= sites) begin
        res.site_out_of_range = 1'b1;
        return res;
      end
      place_site(int'(pair.site_a), w, l, ax, ay, aqx, aqy);
      place_site(int'(pair.site_b), w, l, bx, by, bqx, bqy);
      sx   = 2 * w;
      sy   = 2 * l;
      best = sep2(ax - bx, ay - by);
      if (aqx != bqx) begin
        if (!aqx) ax += sx; else bx += sx;
        cand = sep2(ax - bx, ay - by);
        if (cand < best) best = cand;
      end
      // y image keeps the x shift, then tries again without it
      if (aqy != bqy) begin
        if (!aqy) ay += sy; else by += sy;
        cand = sep2(ax - bx, ay - by);
        if (cand < best) best = cand;
        if (aqx != bqx) begin
          if (!aqx) ax -= sx; else bx -= sx;
          cand = sep2(ax - bx, ay - by);
          if (cand < best) best = cand;
        end
      end
      res.squared_distance = (best > int'(lmid_pkg::DIST_MAX)) ? lmid_pkg::DIST_MAX :
                                                                  DIST_W'(best);
      return res;
    endfunction

    function void note_pair(lmid_pkg::in_item_t pair);
      expected_dist_q.push_back(min_image(pair));
    endfunction

    function void check_result(lmid_pkg::out_item_t got);
      lmid_pkg::out_item_t want;
      if (expected_dist_q.size() == 0) begin
        $display("%0t: unexpected result, actual dist %0d oor %0b", $time,
                 got.squared_distance, got.site_out_of_range);
        errors++;
        return;
      end
      want = expected_dist_q.pop_front();
      if (got.squared_distance !== want.squared_distance) begin
        $display("%0t: squared_distance expected %0d actual %0d", $time,
                 want.squared_distance, got.squared_distance);
        errors++;
      end
      if (got.site_out_of_range !== want.site_out_of_range) begin
        $display("%0t: site_out_of_range expected %0b actual %0b", $time,
                 want.site_out_of_range, got.site_out_of_range);
        errors++;
      end
    endfunction

    function int pending();
      return expected_dist_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  lmid_stream_if #(.payload_t(lmid_pkg::in_item_t))  in_if ();
  lmid_stream_if #(.payload_t(lmid_pkg::out_item_t)) out_if ();

  lieb_min_image_distance uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  lattice_distance_board board;
  int src_idle_pct;
  int sink_stall_pct;
  bit hold_req;
  int stall_cycles;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) board.note_pair(in_if.payload);
    if (rst_ni && out_if.valid && out_if.ready) board.check_result(out_if.payload);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_pair(logic [SITE_W-1:0] sa, logic [SITE_W-1:0] sb);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{site_a: sa, site_b: sb};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // caller lowers the write enable after the last write
  task automatic write_reg(lmid_pkg::cfg_reg_e idx, logic [CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    board.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // mostly valid sites, with boundary and full-range noise mixed in
  function automatic logic [SITE_W-1:0] pick_site(int sites);
    int r;
    r = $urandom_range(99);
    if (r < 85) return SITE_W'($urandom_range(sites - 1));
    if (r < 93) return SITE_W'($urandom_range(SITE_TOP));
    case ($urandom_range(3))
      0: return '0;
      1: return SITE_W'(sites - 1);
      2: return SITE_W'(sites);
      default: return SITE_W'(SITE_TOP);
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0]  ph_w [NUM_PHASES];
    logic [CFG_W-1:0]  ph_l [NUM_PHASES];
    int                ph_src [NUM_PHASES];
    int                ph_sink [NUM_PHASES];
    logic [SITE_W-1:0] dir_a [18];
    logic [SITE_W-1:0] dir_b [18];
    int sites;

    ph_w    = '{7'd4, 7'd1, 7'd64, 7'd0, 7'd127, 7'd64, 7'd1, 7'd3, 7'd0, 7'd0};
    ph_l    = '{7'd4, 7'd1, 7'd64, 7'd0, 7'd127, 7'd1, 7'd64, 7'd5, 7'd0, 7'd0};
    ph_src  = '{0, 0, 78, 0, 27, 0, 78, 0, 27, 0};
    ph_sink = '{0, 0, 0, 78, 27, 0, 0, 78, 27, 0};
    ph_w[8] = CFG_W'($urandom_range(127));
    ph_l[8] = CFG_W'($urandom_range(127));
    ph_w[9] = CFG_W'($urandom_range(127));
    ph_l[9] = CFG_W'($urandom_range(127));

    // 4x4 lattice, 48 sites: sublattice offsets, quarter crossings, range edges
    dir_a = '{0, 0, 0, 1, 0, 0, 0, 45, 11, 47, 47, 0, 48, 0, 16383, 0, 16383, 24};
    dir_b = '{0, 1, 2, 2, 9, 36, 45, 0, 38, 47, 0, 47, 0, 48, 0, 16383, 16383, 23};

    board          = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = lmid_pkg::CFG_LATTICE_WIDTH;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        write_reg(lmid_pkg::CFG_LATTICE_WIDTH, ph_w[p]);
        write_reg(lmid_pkg::CFG_LATTICE_LENGTH, ph_l[p]);
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end
      src_idle_pct   = ph_src[p];
      sink_stall_pct = ph_sink[p];
      sites = 3 * board.side_used(board.width_reg) * board.side_used(board.length_reg);
      if (p == 0) begin
        foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i]);
      end
      // sender keeps offering while the output is held off
      if (p == 1) hold_req = 1'b1;
      repeat (PAIRS_PER_PH) send_pair(pick_site(sites), pick_site(sites));
      drain_pipe();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    board.errors += board.pending();
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== lieb_min_image_distance.f =====
rtl/lmid_pkg.sv
rtl/lmid_stream_if.sv
rtl/lieb_min_image_distance.sv
tb/sv/lieb_min_image_distance_test.sv
